@@ sv/sha1he_pkg.sv @@
package sha1he_pkg;

	// working words a..e, also used for the chaining value
	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		logic [31:0] d;
		logic [31:0] e;
	} work_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_ROUND,
		ST_FOLD,
		ST_PAD_HEAD,
		ST_PAD_FILL,
		ST_EMIT
	} state_t;

	localparam logic [31:0] K_CH  = 32'h5A827999;
	localparam logic [31:0] K_PAR = 32'h6ED9EBA1;
	localparam logic [31:0] K_MAJ = 32'h8F1BBCDC;
	localparam logic [31:0] K_LAST = 32'hCA62C1D6;

	localparam work_t INIT_CHAIN = '{
		a: 32'h67452301,
		b: 32'hEFCDAB89,
		c: 32'h98BADCFE,
		d: 32'h10325476,
		e: 32'hC3D2E1F0
	};

	localparam logic [7:0] PAD_BYTE   = 8'h80;
	localparam logic [6:0] LAST_ROUND = 7'd79;
	localparam logic [2:0] LAST_IDX   = 3'd4;

	function automatic logic [31:0] rotl1(input logic [31:0] x);
		return {x[30:0], x[31]};
	endfunction

	function automatic logic [31:0] rotl5(input logic [31:0] x);
		return {x[26:0], x[31:27]};
	endfunction

	function automatic logic [31:0] rotl30(input logic [31:0] x);
		return {x[1:0], x[31:2]};
	endfunction

endpackage

@@ sv/sha1he_round.sv @@
module sha1he_round (
	input  sha1he_pkg::work_t cur,
	input  logic [31:0]       w,
	input  logic [6:0]        rnd,
	output sha1he_pkg::work_t nxt
);

	logic [31:0] f;
	logic [31:0] k;

	always_comb begin
		if (rnd < 7'd20) begin
			f = (cur.b & cur.c) | (~cur.b & cur.d);
			k = sha1he_pkg::K_CH;
		end else if (rnd < 7'd40) begin
			f = cur.b ^ cur.c ^ cur.d;
			k = sha1he_pkg::K_PAR;
		end else if (rnd < 7'd60) begin
			f = (cur.b & cur.c) | (cur.b & cur.d) | (cur.c & cur.d);
			k = sha1he_pkg::K_MAJ;
		end else begin
			f = cur.b ^ cur.c ^ cur.d;
			k = sha1he_pkg::K_LAST;
		end
	end

	always_comb begin
		nxt.a = sha1he_pkg::rotl5(cur.a) + f + cur.e + k + w;
		nxt.b = cur.a;
		nxt.c = sha1he_pkg::rotl30(cur.b);
		nxt.d = cur.c;
		nxt.e = cur.d;
	end

endmodule

@@ sv/sha1_hash_engine_unit.sv @@
// SHA-1 engine for one byte-stream message at a time. Bytes are packed big-endian into a
// 16-word block memory; each full 64-byte block is compressed one round per clock. Byte beats
// are taken one per cycle while the engine is idle, and the beat that completes a block is
// followed by a busy phase (a memory prefetch, the rounds, a chaining add) on the single round
// unit, so no new byte is taken while a block is compressed. The end-of-message beat adds padding:
// a head write, then a memory write per remaining word of the block and a turnaround
// step, a compression, and a second padded block when fewer than 9 bytes are left; the five
// digest words then leave most significant first, one beat per cycle when the output is not
// stalled. in_stall is high whenever the engine is busy. After the last digest word the engine
// is ready for a new message.
module sha1_hash_engine_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        has_byte,
	input  logic        end_of_message,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);

	sha1he_pkg::state_t state_q, state_d;

	logic [60:0] cnt_q;
	logic [23:0] acc_q;
	logic        fin_pend_q;
	logic        pad_active_q;
	logic        len_blk_q;
	logic [4:0]  idx_q;
	logic [6:0]  rnd_q;
	logic [2:0]  oidx_q;

	sha1he_pkg::work_t work_q, chain_q, work_nxt;
	logic [31:0] win_q [16];

	logic [31:0] blk_mem [16];
	logic [31:0] rd_data_q;
	logic        mem_we;
	logic [3:0]  mem_waddr;
	logic [31:0] mem_wdata;
	logic [3:0]  mem_raddr;

	logic        in_acc;
	logic [5:0]  pos;
	logic [31:0] head_word;
	logic [31:0] round_w;
	logic        load_out;
	logic [31:0] chain_sel;

	assign in_stall = (state_q != sha1he_pkg::ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign pos      = cnt_q[5:0];
	assign load_out = !out_valid || !out_stall;

	// first pad word: bytes already taken, then the 0x80 marker, then zeros
	always_comb begin
		case (pos[1:0])
			2'd0: head_word = {sha1he_pkg::PAD_BYTE, 24'h0};
			2'd1: head_word = {acc_q[23:16], sha1he_pkg::PAD_BYTE, 16'h0};
			2'd2: head_word = {acc_q[23:8], sha1he_pkg::PAD_BYTE, 8'h0};
			default: head_word = {acc_q, sha1he_pkg::PAD_BYTE};
		endcase
	end

	always_comb begin
		if (rnd_q[6:4] == 3'd0) begin
			round_w = rd_data_q;
		end else begin
			round_w = sha1he_pkg::rotl1(win_q[13] ^ win_q[8] ^ win_q[2] ^ win_q[0]);
		end
	end

	always_comb begin
		unique case (oidx_q)
			3'd0: chain_sel = chain_q.a;
			3'd1: chain_sel = chain_q.b;
			3'd2: chain_sel = chain_q.c;
			3'd3: chain_sel = chain_q.d;
			default: chain_sel = chain_q.e;
		endcase
	end

	sha1he_round u_round (
		.cur (work_q),
		.w   (round_w),
		.rnd (rnd_q),
		.nxt (work_nxt)
	);

	// Writes happen only while loading or padding, and the read data is used only while
	// compressing, so a read that matters never overlaps a write of the same word.
	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_waddr = pos[5:2];
		mem_wdata = {acc_q, data_byte};
		mem_raddr = 4'd0;
		unique case (state_q)
			sha1he_pkg::ST_IDLE: begin
				if (in_acc) begin
					if (has_byte && pos[1:0] == 2'd3) begin
						mem_we = 1'b1;
					end
					if (has_byte && pos == 6'd63) begin
						state_d = sha1he_pkg::ST_PREP;
					end else if (end_of_message) begin
						state_d = sha1he_pkg::ST_PAD_HEAD;
					end
				end
			end
			sha1he_pkg::ST_PAD_HEAD: begin
				mem_we    = 1'b1;
				mem_wdata = head_word;
				state_d   = sha1he_pkg::ST_PAD_FILL;
			end
			sha1he_pkg::ST_PAD_FILL: begin
				mem_waddr = idx_q[3:0];
				if (len_blk_q && idx_q[3:0] == 4'd14) begin
					mem_wdata = cnt_q[60:29];
				end else if (len_blk_q && idx_q[3:0] == 4'd15) begin
					mem_wdata = {cnt_q[28:0], 3'b000};
				end else begin
					mem_wdata = 32'h0;
				end
				if (idx_q[4]) begin
					state_d = sha1he_pkg::ST_PREP;
				end else begin
					mem_we = 1'b1;
				end
			end
			sha1he_pkg::ST_PREP: begin
				state_d = sha1he_pkg::ST_ROUND;
			end
			sha1he_pkg::ST_ROUND: begin
				mem_raddr = rnd_q[3:0] + 4'd1;
				if (rnd_q == sha1he_pkg::LAST_ROUND) begin
					state_d = sha1he_pkg::ST_FOLD;
				end
			end
			sha1he_pkg::ST_FOLD: begin
				if (pad_active_q) begin
					state_d = len_blk_q ? sha1he_pkg::ST_EMIT : sha1he_pkg::ST_PAD_FILL;
				end else if (fin_pend_q) begin
					state_d = sha1he_pkg::ST_PAD_HEAD;
				end else begin
					state_d = sha1he_pkg::ST_IDLE;
				end
			end
			sha1he_pkg::ST_EMIT: begin
				if (load_out && oidx_q == sha1he_pkg::LAST_IDX) begin
					state_d = sha1he_pkg::ST_IDLE;
				end
			end
			default: state_d = sha1he_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sha1he_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			blk_mem[mem_waddr] <= mem_wdata;
		end
		rd_data_q <= blk_mem[mem_raddr];
	end

	// byte packing: the first three bytes of a word wait here until the fourth arrives
	always_ff @(posedge clk) begin
		if (in_acc && has_byte) begin
			case (pos[1:0])
				2'd0: acc_q[23:16] <= data_byte;
				2'd1: acc_q[15:8]  <= data_byte;
				2'd2: acc_q[7:0]   <= data_byte;
				default: acc_q <= acc_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == sha1he_pkg::ST_PREP) begin
			work_q <= chain_q;
		end else if (state_q == sha1he_pkg::ST_ROUND) begin
			work_q <= work_nxt;
			for (int i = 0; i < 15; i++) begin
				win_q[i] <= win_q[i + 1];
			end
			win_q[15] <= round_w;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q        <= '0;
			fin_pend_q   <= 1'b0;
			pad_active_q <= 1'b0;
			len_blk_q    <= 1'b0;
			idx_q        <= '0;
			rnd_q        <= '0;
			oidx_q       <= '0;
			chain_q      <= sha1he_pkg::INIT_CHAIN;
		end else begin
			unique case (state_q)
				sha1he_pkg::ST_IDLE: begin
					if (in_acc) begin
						if (has_byte) begin
							cnt_q <= cnt_q + 61'd1;
						end
						fin_pend_q <= end_of_message && has_byte && pos == 6'd63;
					end
				end
				sha1he_pkg::ST_PAD_HEAD: begin
					idx_q        <= {1'b0, pos[5:2]} + 5'd1;
					len_blk_q    <= (pos[5:3] != 3'b111);
					pad_active_q <= 1'b1;
				end
				sha1he_pkg::ST_PAD_FILL: begin
					if (!idx_q[4]) begin
						idx_q <= idx_q + 5'd1;
					end
				end
				sha1he_pkg::ST_PREP: begin
					rnd_q <= '0;
				end
				sha1he_pkg::ST_ROUND: begin
					rnd_q <= rnd_q + 7'd1;
				end
				sha1he_pkg::ST_FOLD: begin
					chain_q.a  <= chain_q.a + work_q.a;
					chain_q.b  <= chain_q.b + work_q.b;
					chain_q.c  <= chain_q.c + work_q.c;
					chain_q.d  <= chain_q.d + work_q.d;
					chain_q.e  <= chain_q.e + work_q.e;
					fin_pend_q <= 1'b0;
					oidx_q     <= '0;
					rnd_q      <= '0;
					// length did not fit: a second, all-zero block carries it
					if (pad_active_q && !len_blk_q) begin
						idx_q     <= '0;
						len_blk_q <= 1'b1;
					end
				end
				sha1he_pkg::ST_EMIT: begin
					if (load_out) begin
						if (oidx_q == sha1he_pkg::LAST_IDX) begin
							chain_q      <= sha1he_pkg::INIT_CHAIN;
							cnt_q        <= '0;
							pad_active_q <= 1'b0;
						end else begin
							oidx_q <= oidx_q + 3'd1;
						end
					end
				end
				default: begin
					rnd_q <= '0;
				end
			endcase
		end
	end

	// output register: refills in the same cycle the previous beat leaves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (state_q == sha1he_pkg::ST_EMIT && load_out) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == sha1he_pkg::ST_EMIT && load_out) begin
			digest_word <= chain_sel;
			word_index  <= oidx_q;
			last_word   <= (oidx_q == sha1he_pkg::LAST_IDX);
		end
	end

endmodule

@@ sv/sha1he_checker.sv @@
module sha1he_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] digest_word,
	input logic [2:0]  word_index,
	input logic        last_word
);

	// last flag marks exactly the final digest word
	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last_word == (word_index == sha1he_pkg::LAST_IDX)))
		else $error("last_word does not match word_index");

	// digest words leave back to back in order
	a_word_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && word_index != sha1he_pkg::LAST_IDX |=>
		out_valid && word_index == $past(word_index) + 3'd1)
		else $error("digest word sequence broken");

	// no new input while a digest is still being sent
	a_busy_emit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && word_index != sha1he_pkg::LAST_IDX |-> in_stall)
		else $error("input taken during digest output");

	// a stalled beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=>
		out_valid && $stable(digest_word) && $stable(word_index))
		else $error("stalled output beat changed");

endmodule

bind sha1_hash_engine_unit sha1he_checker u_sha1he_checker (.*);

@@ bench/tb_sha1_hash_engine_unit.sv @@
module tb_sha1_hash_engine_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_LIMIT   = 4000;
	localparam int DRAIN_CYCLES = 400;
	localparam int HOLD_START   = 1500;
	localparam int HOLD_CYCLES  = 450;
	localparam int ITEM_TARGET  = 420;

	typedef struct {
		logic [7:0] data;
		logic       has;
		logic       eom;
	} msg_beat_t;

	typedef struct {
		logic [31:0] word;
		logic [2:0]  idx;
		logic        last;
	} digest_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte = 8'h00;
	logic        has_byte = 1'b0;
	logic        end_of_message = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	msg_beat_t    beat_q[$];
	digest_beat_t digest_q[$];
	int           err_cnt = 0;
	int           n_items = 0;

	// hash state mirrored from the block
	logic [31:0] chain_h[5];
	logic [31:0] blk_w[16];
	logic [60:0] msg_len;

	sha1_hash_engine_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.data_byte(data_byte),
		.has_byte(has_byte),
		.end_of_message(end_of_message),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.digest_word(digest_word),
		.word_index(word_index),
		.last_word(last_word)
	);

	always #5ns clk = ~clk;

	task automatic hash_restart();
		chain_h[0] = sha1he_pkg::INIT_CHAIN.a;
		chain_h[1] = sha1he_pkg::INIT_CHAIN.b;
		chain_h[2] = sha1he_pkg::INIT_CHAIN.c;
		chain_h[3] = sha1he_pkg::INIT_CHAIN.d;
		chain_h[4] = sha1he_pkg::INIT_CHAIN.e;
		msg_len = '0;
	endtask

	task automatic compress_blk();
		logic [31:0] sched[16];
		logic [31:0] a, b, c, d, e, f, k, t, x;
		int s;
		sched = blk_w;
		a = chain_h[0];
		b = chain_h[1];
		c = chain_h[2];
		d = chain_h[3];
		e = chain_h[4];
		for (int r = 0; r < 80; r++) begin
			s = r % 16;
			if (r >= 16) begin
				x = sched[(s + 13) % 16] ^ sched[(s + 8) % 16] ^ sched[(s + 2) % 16] ^ sched[s];
				sched[s] = {x[30:0], x[31]};
			end
			if (r < 20) begin
				f = (b & c) | (~b & d);
				k = sha1he_pkg::K_CH;
			end else if (r < 40) begin
				f = b ^ c ^ d;
				k = sha1he_pkg::K_PAR;
			end else if (r < 60) begin
				f = (b & c) | (b & d) | (c & d);
				k = sha1he_pkg::K_MAJ;
			end else begin
				f = b ^ c ^ d;
				k = sha1he_pkg::K_LAST;
			end
			t = {a[26:0], a[31:27]} + f + e + k + sched[s];
			e = d;
			d = c;
			c = {b[1:0], b[31:2]};
			b = a;
			a = t;
		end
		chain_h[0] += a;
		chain_h[1] += b;
		chain_h[2] += c;
		chain_h[3] += d;
		chain_h[4] += e;
	endtask

	// big-endian byte lane within the 16-word block
	task automatic pack_byte(input logic [5:0] pos, input logic [7:0] v);
		if (pos[1:0] == 2'd0)
			blk_w[pos[5:2]] = {v, 24'h0};
		else
			blk_w[pos[5:2]] |= 32'(v) << (24 - 8 * pos[1:0]);
	endtask

	task automatic sha1_take_item(input logic [7:0] v, input logic has, input logic eom);
		logic [5:0]   pos;
		logic [63:0]  bits;
		digest_beat_t db;
		if (has) begin
			pos = msg_len[5:0];
			pack_byte(pos, v);
			msg_len = msg_len + 61'd1;
			if (pos == 6'd63)
				compress_blk();
		end
		if (eom) begin
			pos = msg_len[5:0];
			pack_byte(pos, sha1he_pkg::PAD_BYTE);
			for (int i = pos[5:2] + 1; i < 16; i++)
				blk_w[i] = '0;
			if (pos >= 6'd56) begin
				compress_blk();
				for (int i = 0; i < 16; i++)
					blk_w[i] = '0;
			end
			bits = {msg_len, 3'b000};
			blk_w[14] = bits[63:32];
			blk_w[15] = bits[31:0];
			compress_blk();
			for (int i = 0; i < 5; i++) begin
				db.word = chain_h[i];
				db.idx = 3'(i);
				db.last = (i == 4);
				digest_q.push_back(db);
			end
			hash_restart();
		end
	endtask

	task automatic add_beat(input logic [7:0] v, input logic has, input logic eom);
		msg_beat_t mb;
		mb.data = v;
		mb.has = has;
		mb.eom = eom;
		beat_q.push_back(mb);
		if (has || eom)
			n_items++;
	endtask

	// len random bytes; the end rides on the last byte or on a byte-less end beat
	task automatic add_message(input int len, input bit end_on_byte);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 15) == 0)
				add_beat(8'($urandom), 1'b0, 1'b0);
			add_beat(8'($urandom), 1'b1, end_on_byte && (i == len - 1));
		end
		if (!end_on_byte || len == 0)
			add_beat(8'($urandom), 1'b0, 1'b1);
	endtask

	// sender: bursts of random length, random gaps
	msg_beat_t drv_beat;
	int        burst_left = 0;
	int        gap_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			burst_left <= 0;
			gap_left <= 0;
			hash_restart();
		end else begin
			if (in_valid && !in_stall)
				sha1_take_item(data_byte, has_byte, end_of_message);
			if (!(in_valid && in_stall)) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (beat_q.size() > 0) begin
					drv_beat = beat_q.pop_front();
					in_valid <= 1'b1;
					data_byte <= drv_beat.data;
					has_byte <= drv_beat.has;
					end_of_message <= drv_beat.eom;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 48);
						gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: random stall density that changes over time, plus one long hold-off
	int rx_cyc = 0;
	int hold_left = 0;
	int phase_left = 0;
	int stall_pct = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			rx_cyc <= 0;
			hold_left <= 0;
			phase_left <= 0;
		end else begin
			rx_cyc <= rx_cyc + 1;
			if (rx_cyc == HOLD_START) begin
				hold_left <= HOLD_CYCLES;
				out_stall <= 1'b1;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				out_stall <= 1'b1;
			end else begin
				if (phase_left == 0) begin
					phase_left <= $urandom_range(20, 120);
					case ($urandom_range(0, 4))
						0, 1: stall_pct <= 0;
						2: stall_pct <= 25;
						3: stall_pct <= 60;
						default: stall_pct <= 90;
					endcase
				end else begin
					phase_left <= phase_left - 1;
				end
				out_stall <= ($urandom_range(0, 99) < stall_pct);
			end
		end
	end

	// checker for digest beats
	digest_beat_t mon_exp;

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (digest_q.size() == 0) begin
				$error("unexpected digest beat: word %h index %0d", digest_word, word_index);
				err_cnt++;
			end else begin
				mon_exp = digest_q.pop_front();
				if (digest_word !== mon_exp.word) begin
					$error("digest_word: expected %h, got %h", mon_exp.word, digest_word);
					err_cnt++;
				end
				if (word_index !== mon_exp.idx) begin
					$error("word_index: expected %0d, got %0d", mon_exp.idx, word_index);
					err_cnt++;
				end
				if (last_word !== mon_exp.last) begin
					$error("last_word: expected %b, got %b", mon_exp.last, last_word);
					err_cnt++;
				end
			end
		end
	end

	int idle_cyc = 0;

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cyc <= 0;
		end else if (idle_cyc >= IDLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end else begin
			idle_cyc <= idle_cyc + 1;
		end
	end

	int len_pick;

	initial begin
		// directed
		add_beat(8'hFF, 1'b0, 1'b0);
		add_beat(8'h5A, 1'b0, 1'b1);
		add_beat(8'hA5, 1'b0, 1'b1);
		add_beat(8'h00, 1'b1, 1'b1);
		add_beat(8'hFF, 1'b1, 1'b1);
		add_beat(8'h61, 1'b1, 1'b0);
		add_beat(8'h62, 1'b1, 1'b0);
		add_beat(8'h63, 1'b1, 1'b1);
		add_beat(8'h61, 1'b1, 1'b0);
		add_beat(8'h00, 1'b0, 1'b0);
		add_beat(8'h62, 1'b1, 1'b0);
		add_beat(8'h63, 1'b1, 1'b0);
		add_beat(8'hC3, 1'b0, 1'b1);
		add_beat(8'h80, 1'b1, 1'b0);
		add_beat(8'h7F, 1'b1, 1'b1);

		// padding boundaries: one block, two blocks, exact block then end beat
		add_message(55, 1'b1);
		add_message(56, 1'b1);
		add_message(63, 1'b0);
		add_message(64, 1'b0);
		while (n_items < ITEM_TARGET) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: len_pick = $urandom_range(0, 12);
				5: begin
					case ($urandom_range(0, 5))
						0: len_pick = 55;
						1: len_pick = 56;
						2: len_pick = 57;
						3: len_pick = 63;
						4: len_pick = 64;
						default: len_pick = 120;
					endcase
				end
				default: len_pick = $urandom_range(13, 70);
			endcase
			add_message(len_pick, 1'($urandom_range(0, 1)));
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (beat_q.size() != 0 || in_valid || digest_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (err_cnt == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

@@ filelist.f @@
sv/sha1he_pkg.sv
sv/sha1he_round.sv
sv/sha1_hash_engine_unit.sv
sv/sha1he_checker.sv
bench/tb_sha1_hash_engine_unit.sv
